### src/uvs_pkg.sv
// uvs_pkg: shared constants, types and arithmetic helpers of the uv sphere vertex generator
// no dependencies
package uvs_pkg;

   localparam int unsigned MAX_SEGMENTS = 255;

   // request modes; any other code is handled as the bottom pole
   localparam logic [1:0] MODE_TOP  = 2'd0;
   localparam logic [1:0] MODE_GRID = 2'd1;

   // register indexes
   localparam int unsigned     CSR_IDX_W        = 3;
   localparam logic [2:0]      CSR_RING_COUNT   = 3'd0;
   localparam logic [2:0]      CSR_STEP_COUNT   = 3'd1;
   localparam logic [2:0]      CSR_RADIUS       = 3'd2;
   localparam logic [2:0]      CSR_CENTER_X     = 3'd3;
   localparam logic [2:0]      CSR_CENTER_Y     = 3'd4;
   localparam logic [2:0]      CSR_CENTER_Z     = 3'd5;

   // divider geometry
   localparam int unsigned DIV_NUM_W     = 24;
   localparam int unsigned DIV_BITS_STG  = 4;
   localparam int unsigned DIV_STAGES    = DIV_NUM_W / DIV_BITS_STG;

   // quarter wave polynomial coefficients, q30
   localparam logic [30:0] POLY_A   = 31'd1686629713;
   localparam logic [29:0] POLY_B   = 30'd688904866;
   localparam logic [26:0] POLY_C   = 27'd76016977;
   localparam logic [29:0] Q30_HALF = 30'd536870912;

   typedef struct packed {
      logic        valid;
      logic [1:0]  mode;
      logic [7:0]  ring;
      logic [7:0]  step;
      logic [15:0] self_idx;
      logic [15:0] upper_idx;
      logic [15:0] ring_idx;
      logic        bottom_edge;
      logic [15:0] bottom_idx;
   } ctrl_type;

   function automatic logic [7:0] clamp_count(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == 8'd0) r = 8'd1;
      else if (32'(c) > MAX_SEGMENTS) r = 8'(MAX_SEGMENTS);
      return r;
   endfunction

   // (a*b) >> 30, rounded half away from zero
   function automatic logic signed [34:0] mul_round30(input logic signed [32:0] a,
                                                      input logic signed [32:0] b);
      logic        neg;
      logic [32:0] ma;
      logic [32:0] mb;
      logic [65:0] p;
      logic [34:0] m;
      neg = a[32] ^ b[32];
      ma  = a[32] ? 33'(-a) : 33'(a);
      mb  = b[32] ? 33'(-b) : 33'(b);
      p   = 66'(ma) * 66'(mb) + 66'(Q30_HALF);
      m   = 35'(p >> 30);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [28:0] rad_scale(input logic [22:0] rad,
                                                    input logic signed [34:0] v);
      logic [34:0] mv;
      logic [57:0] p;
      logic [28:0] m;
      mv = v[34] ? 35'(-v) : 35'(v);
      p  = 58'(rad) * 58'(mv) + 58'(Q30_HALF);
      m  = 29'(p >> 30);
      return v[34] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [23:0] sat24(input logic signed [29:0] v);
      logic [23:0] r;
      if (v > 30'sd8388607) r = 24'h7FFFFF;
      else if (v < -30'sd8388608) r = 24'h800000;
      else r = v[23:0];
      return r;
   endfunction

endpackage

### src/uvs_div.sv
// uvs_div: pipelined restoring divider, 24-bit dividend by 8-bit divisor
// depends on uvs_pkg; gives the low 16 quotient bits (an angle phase)
module uvs_div (
   input  logic                         clock,
   input  logic [uvs_pkg::DIV_NUM_W-1:0] num,
   input  logic [7:0]                   dvs,
   output logic [15:0]                  quo
);
   import uvs_pkg::*;

   logic [7:0]           rem_w [0:DIV_STAGES];
   logic [DIV_NUM_W-1:0] num_w [0:DIV_STAGES];
   logic [15:0]          quo_w [0:DIV_STAGES];
   logic [7:0]           dvs_w [0:DIV_STAGES];

   assign rem_w[0] = '0;
   assign num_w[0] = num;
   assign quo_w[0] = '0;
   assign dvs_w[0] = dvs;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [7:0]           rem_in, rem_ff;
      logic [DIV_NUM_W-1:0] num_in, num_ff;
      logic [15:0]          quo_in, quo_ff;
      logic [7:0]           dvs_ff;

      always_comb begin
         logic [8:0] trial;
         rem_in = rem_w[g];
         num_in = num_w[g];
         quo_in = quo_w[g];
         trial  = '0;
         for (int i = 0; i < DIV_BITS_STG; i++) begin
            trial  = {rem_in, num_in[DIV_NUM_W-1]};
            num_in = {num_in[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_w[g]}) begin
               trial  = trial - {1'b0, dvs_w[g]};
               quo_in = {quo_in[14:0], 1'b1};
            end else begin
               quo_in = {quo_in[14:0], 1'b0};
            end
            rem_in = trial[7:0];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
         dvs_ff <= dvs_w[g];
      end

      assign rem_w[g+1] = rem_ff;
      assign num_w[g+1] = num_ff;
      assign quo_w[g+1] = quo_ff;
      assign dvs_w[g+1] = dvs_ff;
   end

   assign quo = quo_w[DIV_STAGES];

endmodule

### src/uvs_sine.sv
// uvs_sine: four-stage sine of a 16-bit phase, q30 result
// depends on uvs_pkg for the polynomial coefficients
module uvs_sine (
   input  logic               clock,
   input  logic [15:0]        phase,
   output logic signed [32:0] sine
);
   import uvs_pkg::*;

   logic [16:0] r_fold;

   logic [16:0] t1_ff, t2_ff, t3_ff;
   logic [16:0] sq1_ff, sq2_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [29:0] u1_ff;
   logic [30:0] u2_ff;
   logic signed [32:0] sine_ff;

   logic [16:0] sq_in;
   logic [29:0] u1_in;
   logic [30:0] u2_in;
   logic [31:0] v_in;

   // fold into the first quadrant
   always_comb begin
      r_fold = {1'b0, phase[13:0], 2'b00};
      if (phase[14]) r_fold = 17'h10000 - r_fold;
   end

   assign sq_in = 17'((34'(r_fold) * 34'(r_fold)) >> 16);
   assign u1_in = POLY_B - 30'((44'(POLY_C) * 44'(sq1_ff)) >> 16);
   assign u2_in = POLY_A - 31'((47'(u1_ff) * 47'(sq2_ff)) >> 16);
   assign v_in  = 32'((48'(u2_ff) * 48'(t3_ff)) >> 16);

   always_ff @(posedge clock) begin
      t1_ff   <= r_fold;
      sq1_ff  <= sq_in;
      neg1_ff <= phase[15];
      t2_ff   <= t1_ff;
      sq2_ff  <= sq1_ff;
      neg2_ff <= neg1_ff;
      u1_ff   <= u1_in;
      t3_ff   <= t2_ff;
      neg3_ff <= neg2_ff;
      u2_ff   <= u2_in;
      sine_ff <= neg3_ff ? -$signed({1'b0, v_in}) : $signed({1'b0, v_in});
   end

   assign sine = sine_ff;

endmodule

### src/uv_sphere_wire_vertex_gen_core.sv
// uv_sphere_wire_vertex_gen_core: top level, one vertex with position and edges per request
// depends on uvs_pkg, uvs_div and uvs_sine
// result path: every mode takes the same pipeline from the accepting edge to the result strobe
// throughput: one request per cycle; busy is always low, the pipeline never stalls
// the 6-stage angle divider and the 4-stage sine polynomial feed direction and radius scaling
// reset: registers return to their defaults, requests in flight are dropped
module uv_sphere_wire_vertex_gen_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_mode,
   input  logic [7:0]                     req_ring_index,
   input  logic [7:0]                     req_step_index,
   output logic                           rsp_strobe,
   output logic [15:0]                    rsp_vertex_index,
   output logic signed [23:0]             rsp_pos_x,
   output logic signed [23:0]             rsp_pos_y,
   output logic signed [23:0]             rsp_pos_z,
   output logic                           rsp_edges_valid,
   output logic [15:0]                    rsp_upper_edge_from,
   output logic [15:0]                    rsp_ring_edge_from,
   output logic                           rsp_bottom_edge_valid,
   output logic [15:0]                    rsp_bottom_pole_index,
   input  logic                           csr_we,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [23:0]                    csr_wdata
);
   import uvs_pkg::*;

   // control line depth: entry 0 is loaded at the transfer and each entry feeds the next
   localparam int unsigned CTRL_DEPTH = DIV_STAGES + 7;
   localparam int unsigned LATENCY    = CTRL_DEPTH;

   // configuration registers
   logic [7:0]         ring_count_ff, step_count_ff;
   logic [22:0]        radius_ff;
   logic signed [23:0] center_x_ff, center_y_ff, center_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff <= 8'd8;
         step_count_ff <= 8'd16;
         radius_ff     <= 23'd256;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         center_z_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RING_COUNT: ring_count_ff <= csr_wdata[7:0];
            CSR_STEP_COUNT: step_count_ff <= csr_wdata[7:0];
            CSR_RADIUS:     radius_ff     <= csr_wdata[22:0];
            CSR_CENTER_X:   center_x_ff   <= csr_wdata;
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata;
            CSR_CENTER_Z:   center_z_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [7:0] rc, sc;
   assign rc = clamp_count(ring_count_ff);
   assign sc = clamp_count(step_count_ff);

   // request transfer
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // stage 0: indices and angle numerators
   ctrl_type ctrl_ff [0:CTRL_DEPTH-1];
   ctrl_type ctrl0_in, ctrl1_in;
   logic [DIV_NUM_W-1:0] lat_num_ff, lon_num_ff;
   logic [7:0]           rc_ff, sc_ff;

   always_comb begin
      ctrl0_in            = '0;
      ctrl0_in.valid      = accept;
      ctrl0_in.mode       = req_mode;
      ctrl0_in.ring       = req_ring_index;
      ctrl0_in.step       = req_step_index;
      ctrl0_in.self_idx   = 16'd1 + 16'(req_ring_index) * 16'(sc) + 16'(req_step_index);
      ctrl0_in.bottom_idx = 16'd1 + 16'(rc) * 16'(sc);
   end

   // stage 1: edge endpoints from the vertex index
   always_comb begin
      ctrl1_in = ctrl_ff[0];
      ctrl1_in.upper_idx = (ctrl_ff[0].ring == 8'd0) ? 16'd0
                                                      : ctrl_ff[0].self_idx - 16'(sc);
      ctrl1_in.ring_idx  = (ctrl_ff[0].step == 8'd0)
                           ? ctrl_ff[0].self_idx + 16'(sc) - 16'd1
                           : ctrl_ff[0].self_idx - 16'd1;
      ctrl1_in.bottom_edge = (rc > 8'd1) && (ctrl_ff[0].ring == rc - 8'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CTRL_DEPTH; k++) ctrl_ff[k].valid <= 1'b0;
      end else begin
         ctrl_ff[0] <= ctrl0_in;
         ctrl_ff[1] <= ctrl1_in;
         for (int k = 2; k < CTRL_DEPTH; k++) ctrl_ff[k] <= ctrl_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      lat_num_ff <= {1'b0, req_ring_index, 15'd0} + DIV_NUM_W'(rc >> 1);
      lon_num_ff <= {req_step_index, 16'd0} + DIV_NUM_W'(sc >> 1);
      rc_ff      <= rc;
      sc_ff      <= sc;
   end

   // angle phases, half turn per ring count and full turn per step count
   logic [15:0] lat_phase, lon_phase;

   uvs_div u_lat_div (.clock(clock), .num(lat_num_ff), .dvs(rc_ff), .quo(lat_phase));
   uvs_div u_lon_div (.clock(clock), .num(lon_num_ff), .dvs(sc_ff), .quo(lon_phase));

   // sines; cosine is the sine a quarter turn later
   logic signed [32:0] sin_lat, cos_lat, sin_lon, cos_lon;

   uvs_sine u_sin_lat (.clock(clock), .phase(lat_phase), .sine(sin_lat));
   uvs_sine u_cos_lat (.clock(clock), .phase(lat_phase + 16'h4000), .sine(cos_lat));
   uvs_sine u_sin_lon (.clock(clock), .phase(lon_phase), .sine(sin_lon));
   uvs_sine u_cos_lon (.clock(clock), .phase(lon_phase + 16'h4000), .sine(cos_lon));

   // direction products, then radius scaling
   logic signed [34:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic signed [28:0] off_x_ff, off_y_ff, off_z_ff;

   always_ff @(posedge clock) begin
      dir_x_ff <= mul_round30(sin_lat, cos_lon);
      dir_y_ff <= mul_round30(sin_lat, sin_lon);
      dir_z_ff <= 35'(cos_lat);
      off_x_ff <= rad_scale(radius_ff, dir_x_ff);
      off_y_ff <= rad_scale(radius_ff, dir_y_ff);
      off_z_ff <= rad_scale(radius_ff, dir_z_ff);
   end

   // final stage: center add, pole select, saturation
   ctrl_type           last;
   logic               is_grid, is_top;
   logic signed [29:0] sum_x, sum_y, sum_z;

   assign last    = ctrl_ff[CTRL_DEPTH-1];
   assign is_grid = (last.mode == MODE_GRID);
   assign is_top  = (last.mode == MODE_TOP);

   always_comb begin
      if (is_grid) begin
         sum_x = 30'(center_x_ff) + 30'(off_x_ff);
         sum_y = 30'(center_y_ff) + 30'(off_y_ff);
         sum_z = 30'(center_z_ff) + 30'(off_z_ff);
      end else begin
         sum_x = 30'(center_x_ff);
         sum_y = 30'(center_y_ff);
         sum_z = is_top ? 30'(center_z_ff) + $signed(30'(radius_ff))
                        : 30'(center_z_ff) - $signed(30'(radius_ff));
      end
   end

   logic        rsp_strobe_ff;
   logic [15:0] rsp_vertex_index_ff, rsp_upper_ff, rsp_ring_ff, rsp_bottom_idx_ff;
   logic [23:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;
   logic        rsp_edges_ff, rsp_bottom_edge_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= last.valid;
   end

   always_ff @(posedge clock) begin
      rsp_vertex_index_ff <= is_grid ? last.self_idx : (is_top ? 16'd0 : last.bottom_idx);
      rsp_pos_x_ff        <= sat24(sum_x);
      rsp_pos_y_ff        <= sat24(sum_y);
      rsp_pos_z_ff        <= sat24(sum_z);
      rsp_edges_ff        <= is_grid;
      rsp_upper_ff        <= is_grid ? last.upper_idx : 16'd0;
      rsp_ring_ff         <= is_grid ? last.ring_idx : 16'd0;
      rsp_bottom_edge_ff  <= is_grid && last.bottom_edge;
      rsp_bottom_idx_ff   <= last.bottom_idx;
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_vertex_index      = rsp_vertex_index_ff;
   assign rsp_pos_x             = rsp_pos_x_ff;
   assign rsp_pos_y             = rsp_pos_y_ff;
   assign rsp_pos_z             = rsp_pos_z_ff;
   assign rsp_edges_valid       = rsp_edges_ff;
   assign rsp_upper_edge_from   = rsp_upper_ff;
   assign rsp_ring_edge_from    = rsp_ring_ff;
   assign rsp_bottom_edge_valid = rsp_bottom_edge_ff;
   assign rsp_bottom_pole_index = rsp_bottom_idx_ff;

   // every transfer is followed by its result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LATENCY + 1) rsp_strobe)
      else $error("result strobe missing after request transfer");

   // poles carry no edges
   a_pole_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_edges_valid |->
         rsp_upper_edge_from == 16'd0 && rsp_ring_edge_from == 16'd0 &&
         !rsp_bottom_edge_valid)
      else $error("pole result carries edges");

   // bottom edge only on a grid point
   a_bottom_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_bottom_edge_valid |-> rsp_edges_valid)
      else $error("bottom edge without grid point");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

### test/tb_uv_sphere_wire_vertex_gen_core.sv
// tb_uv_sphere_wire_vertex_gen_core: self-checking testbench of the uv sphere vertex generator
// drives requests and register writes, predicts each vertex in a scoreboard class and compares
// depends on uvs_pkg and uv_sphere_wire_vertex_gen_core
`timescale 1ns / 100ps

module tb_uv_sphere_wire_vertex_gen_core;
   import uvs_pkg::*;

   typedef struct packed {
      logic [15:0] vidx;
      logic [23:0] px, py, pz;
      logic        edges;
      logic [15:0] upper, ring_from;
      logic        bot_edge;
      logic [15:0] bot_idx;
   } vertex_type;

   // scoreboard: own copy of the registers, expected vertex queue
   class vertex_scoreboard;
      logic [7:0]         rings, steps;
      logic [22:0]        radius;
      logic signed [23:0] cx, cy, cz;
      vertex_type         pending[$];
      int                 errors;

      function void clear_regs();
         rings = 8'd8; steps = 8'd16; radius = 23'd256; cx = 0; cy = 0; cz = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            CSR_RING_COUNT: rings = val[7:0];
            CSR_STEP_COUNT: steps = val[7:0];
            CSR_RADIUS: radius = val[22:0];
            CSR_CENTER_X: cx = val;
            CSR_CENTER_Y: cy = val;
            CSR_CENTER_Z: cz = val;
            default: ;
         endcase
      endfunction

      function longint unsigned qsine(longint unsigned t);
         longint unsigned t2, u;
         t2 = (t * t) >> 16;
         u  = (64'd76016977 * t2) >> 16;
         u  = 64'd688904866 - u;
         u  = (u * t2) >> 16;
         u  = 64'd1686629713 - u;
         return (u * t) >> 16;
      endfunction

      // sine of a 16-bit phase, q30
      function longint phase_sine(int unsigned p);
         int unsigned q, r;
         longint v;
         p = p & 32'hFFFF;
         q = p >> 14;
         r = (p & 32'h3FFF) << 2;
         if (q & 1) r = 65536 - r;
         v = longint'(qsine(r));
         return (q & 2) ? -v : v;
      endfunction

      function longint rmul30(longint a, longint b);
         longint unsigned ma, mb, m;
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         m = (ma * mb + 64'd536870912) >> 30;
         return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
      endfunction

      function logic [23:0] saturate(longint v);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         return v[23:0];
      endfunction

      function int unsigned eff(logic [7:0] c);
         return (c == 0) ? 1 : c;
      endfunction

      // note one accepted request
      function void note_request(logic [1:0] mode, logic [7:0] ring, logic [7:0] step);
         vertex_type e;
         int unsigned rc, sc, lat, lon, self_i;
         longint sl, cl, sn, cn, rad;
         rc = eff(rings); sc = eff(steps); rad = radius;
         e = '{default: '0};
         e.bot_idx = 16'(1 + rc * sc);
         if (mode != MODE_GRID) begin
            e.vidx = (mode == MODE_TOP) ? 16'd0 : e.bot_idx;
            e.px = saturate(cx);
            e.py = saturate(cy);
            e.pz = saturate((mode == MODE_TOP) ? cz + rad : cz - rad);
         end else begin
            lat = (ring * 32768 + rc / 2) / rc;
            lon = (step * 65536 + sc / 2) / sc;
            sl = phase_sine(lat); cl = phase_sine(lat + 16384);
            sn = phase_sine(lon); cn = phase_sine(lon + 16384);
            self_i = 1 + ring * sc + step;
            e.vidx = 16'(self_i);
            e.px = saturate(cx + rmul30(rad, rmul30(sl, cn)));
            e.py = saturate(cy + rmul30(rad, rmul30(sl, sn)));
            e.pz = saturate(cz + rmul30(rad, cl));
            e.edges = 1'b1;
            e.upper = (ring == 0) ? 16'd0 : 16'(1 + (ring - 1) * sc + step);
            e.ring_from = (step == 0) ? 16'(self_i + sc - 1) : 16'(self_i - 1);
            e.bot_edge = (rc > 1 && ring == rc - 1);
         end
         pending = {pending, e};
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_result(vertex_type got);
         vertex_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result, vertex %0d", got.vidx);
            return;
         end
         e = pending.pop_front();
         if (got != e) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: exp idx %0d pos %h %h %h ev %b up %0d rf %0d be %b bp %0d",
                        e.vidx, e.px, e.py, e.pz, e.edges, e.upper, e.ring_from, e.bot_edge,
                        e.bot_idx);
               $display("          got idx %0d pos %h %h %h ev %b up %0d rf %0d be %b bp %0d",
                        got.vidx, got.px, got.py, got.pz, got.edges, got.upper,
                        got.ring_from, got.bot_edge, got.bot_idx);
            end
         end
      endfunction
   endclass

   localparam int LATENCY = 13;
   localparam longint CYCLE_LIMIT = 200000;

   logic        clock = 0, reset = 1, start = 0;
   logic        busy;
   logic [1:0]  req_mode = 0;
   logic [7:0]  req_ring_index = 0, req_step_index = 0;
   logic        rsp_strobe;
   logic [15:0] rsp_vertex_index, rsp_upper_edge_from, rsp_ring_edge_from, rsp_bottom_pole_index;
   logic signed [23:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic        rsp_edges_valid, rsp_bottom_edge_valid;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [23:0] csr_wdata = 0;

   vertex_scoreboard board = new();
   longint cycles = 0;
   bit     quiet = 0;   // long stretch with no idling

   always #6 clock = ~clock;

   uv_sphere_wire_vertex_gen_core dut (.*);

   // result side: sampled at the edge that ends the strobe cycle
   always @(posedge clock) begin
      vertex_type got;
      if (!reset && rsp_strobe) begin
         got.vidx = rsp_vertex_index; got.px = rsp_pos_x; got.py = rsp_pos_y;
         got.pz = rsp_pos_z; got.edges = rsp_edges_valid; got.upper = rsp_upper_edge_from;
         got.ring_from = rsp_ring_edge_from; got.bot_edge = rsp_bottom_edge_valid;
         got.bot_idx = rsp_bottom_pole_index;
         board.check_result(got);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_uv_sphere_wire_vertex_gen_core failed");
         $finish;
      end
   end

   // one register write; the caller drops the write enable after the last one
   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
   endtask

   // one request transfer, with random idle cycles ahead of it
   task automatic send(logic [1:0] mode, logic [7:0] ring, logic [7:0] step);
      while (!quiet && $urandom_range(99) < 7) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1; req_mode <= mode; req_ring_index <= ring; req_step_index <= step;
      do @(posedge clock); while (busy);
      board.note_request(mode, ring, step);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // random request, mostly in range for the current counts
   task automatic random_request();
      int unsigned rc, sc;
      logic [1:0] mode;
      rc = board.eff(board.rings); sc = board.eff(board.steps);
      mode = ($urandom_range(9) < 8) ? MODE_GRID : 2'($urandom_range(3));
      if ($urandom_range(19) == 0)
         send(mode, 8'($urandom), 8'($urandom));
      else
         send(mode, 8'($urandom_range(rc - 1)), 8'($urandom_range(sc - 1)));
   endtask

   task automatic set_shape(logic [7:0] rc, logic [7:0] sc, logic [22:0] rad,
                            logic [23:0] x, logic [23:0] y, logic [23:0] z);
      write_csr(CSR_RING_COUNT, rc);
      write_csr(CSR_STEP_COUNT, sc);
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_CENTER_X, x);
      write_csr(CSR_CENTER_Y, y);
      write_csr(CSR_CENTER_Z, z);
      csr_we <= 0;
   endtask

   initial begin
      board.clear_regs();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset defaults, poles, mode three, wrap and bottom edge
      send(MODE_TOP, 0, 0);
      send(2'd2, 0, 0);
      send(2'd3, 0, 0);
      send(MODE_GRID, 0, 0);
      send(MODE_GRID, 0, 15);
      send(MODE_GRID, 7, 0);
      send(MODE_GRID, 4, 4);
      send(MODE_GRID, 8, 16);
      send(MODE_GRID, 8'hFF, 8'hFF);
      drain();

      // extreme radius and centers, saturation both ways
      set_shape(8'd255, 8'd255, 23'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      send(MODE_TOP, 0, 0);
      send(2'd2, 0, 0);
      send(MODE_GRID, 127, 0);
      send(MODE_GRID, 254, 254);
      send(MODE_GRID, 128, 64);
      drain();
      // zero counts clamp to one; single ring has no bottom edge
      set_shape(8'd0, 8'd0, 23'd0, 24'h800000, 24'h7FFFFF, 24'h800000);
      send(MODE_TOP, 0, 0);
      send(2'd2, 0, 0);
      send(MODE_GRID, 0, 0);
      send(MODE_GRID, 3, 9);
      drain();
      set_shape(8'd1, 8'd1, 23'd1000, 24'd0, 24'd0, 24'd0);
      send(MODE_GRID, 0, 0);
      drain();

      // random phases over several shapes
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_shape(8'd8, 8'd16, 23'd256, 24'd0, 24'd0, 24'd0);
            1: set_shape(8'd2, 8'd3, 23'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h000100);
            default: set_shape(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                               23'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
         endcase
         quiet = (ph == 2);
         for (int n = 0; n < 100; n++) begin
            random_request();
            // let the pipeline run dry once mid-phase
            if (ph == 3 && n == 50) begin
               start <= 0;
               while (board.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_uv_sphere_wire_vertex_gen_core passed");
      else
         $display("tb_uv_sphere_wire_vertex_gen_core failed");
      $finish;
   end

endmodule

### filelist.f
src/uvs_pkg.sv
src/uvs_div.sv
src/uvs_sine.sv
src/uv_sphere_wire_vertex_gen_core.sv
test/tb_uv_sphere_wire_vertex_gen_core.sv
